### hdl/nested_case_duplicate_checker_macros.svh
// ----------------------------------------------------------------------------
// nested case duplicate checker assertion macros
// shared property wrappers, clocked on i_clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef NESTED_CASE_DUPLICATE_CHECKER_MACROS_SVH
`define NESTED_CASE_DUPLICATE_CHECKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NCDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ncdc assertion failed");

// consequent must hold in the cycle after the antecedent
`define NCDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ncdc assertion failed");

`endif

### hdl/ncdc_pkg.sv
// ----------------------------------------------------------------------------
// ncdc_pkg
// types, codes and default sizes of the nested case duplicate checker
// ----------------------------------------------------------------------------
package ncdc_pkg;

    localparam int MAX_NEST_DEF  = 16;
    localparam int MAX_CASES_DEF = 64;

    localparam int REQ_W    = 2;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int DEPTH_OW = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_OPEN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NEST_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SCOPE  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [VAL_W-1:0] case_value;
    } t_req_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DEPTH_OW-1:0] depth;
    } t_rsp_item;

endpackage

### hdl/ncdc_ram.sv
// ----------------------------------------------------------------------------
// ncdc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ncdc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nested_case_duplicate_checker.sv
// ----------------------------------------------------------------------------
// nested_case_duplicate_checker
// stack of open switch scopes, each with a list of case values checked for
// duplicates; the lists live in one ram, the per-scope fill counts in another
// ----------------------------------------------------------------------------
// request channel: i_req_valid / o_req_stall carry one item (req_type,
// case_value). response channel: o_rsp_valid / i_rsp_stall return exactly one
// item (status, depth) per request, in request order.
// open, close, none and refused requests go straight to the final state, which
// loads the response register; an add first reads the count ram, then the
// top scope's list in the case ram is read one entry per cycle with the compare
// in the cycle after each read, then the write-back and the response load.
// the single read port of the case ram sets the pace of the scan.
// only one item is in work at a time; the next item is accepted once the
// previous result sits in the response register, even if it is not taken.
// when the receiver stalls, the result stays in the response register and a
// finished item waits in its last state until the register frees up.
// reset (synchronous, active low) empties the scope stack at once; no
// clearing pass is needed since a count is written on open before it is read
// and only list entries below the count are read.
// ----------------------------------------------------------------------------
module nested_case_duplicate_checker
    import ncdc_pkg::*;
#(
    parameter int MAX_NEST  = MAX_NEST_DEF,
    parameter int MAX_CASES = MAX_CASES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_stall,
    input  t_req_item i_req,
    output logic      o_rsp_valid,
    input  logic      i_rsp_stall,
    output t_rsp_item o_rsp
);

    localparam int DEPTH_W = $clog2(MAX_NEST + 1);
    localparam int TOP_W   = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int CNT_W   = $clog2(MAX_CASES + 1);
    localparam int ST_DEPTH = MAX_NEST * MAX_CASES;
    localparam int ADDR_W  = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CNT  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]          r_state,  n_state;
    logic [DEPTH_W-1:0]  r_open,   n_open;
    logic [TOP_W-1:0]    r_top,    n_top;
    logic [ADDR_W-1:0]   r_base,   n_base;
    logic [VAL_W-1:0]    r_val,    n_val;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic [CNT_W-1:0]    r_idx,    n_idx;
    logic                r_pend,   n_pend;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_rsp_item           r_out,    n_out;

    logic [TOP_W-1:0]  top_now;
    logic              cnt_we;
    logic [TOP_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [ADDR_W-1:0] st_raddr;
    logic [VAL_W-1:0]  st_rdata;
    logic              hit;
    logic              issue;

    ncdc_ram #(
        .WIDTH  (CNT_W),
        .DEPTH  (MAX_NEST),
        .ADDR_W (TOP_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (top_now),
        .o_rdata (cnt_rdata)
    );

    ncdc_ram #(
        .WIDTH  (VAL_W),
        .DEPTH  (ST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_case_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_val),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign top_now  = TOP_W'(r_open - DEPTH_W'(1));
    assign st_waddr = r_base + ADDR_W'(r_cnt);
    assign st_raddr = r_base + ADDR_W'(r_idx);
    // compare uses the read data in the cycle after the read issue
    assign hit      = r_pend && (st_rdata == r_val);
    assign issue    = (r_idx != r_cnt);

    always_comb begin
        n_state     = r_state;
        n_open      = r_open;
        n_top       = r_top;
        n_base      = r_base;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        cnt_we      = 1'b0;
        cnt_waddr   = r_top;
        cnt_wdata   = '0;
        st_we       = 1'b0;

        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_val   = i_req.case_value;
                    n_state = S_FIN;
                    unique case (i_req.req_type)
                        REQ_OPEN: begin
                            if (r_open >= DEPTH_W'(MAX_NEST)) begin
                                n_status = ST_NEST_FULL;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_waddr = TOP_W'(r_open);
                                n_open    = r_open + DEPTH_W'(1);
                                n_status  = ST_OK;
                            end
                        end
                        REQ_ADD: begin
                            if (r_open == '0) begin
                                n_status = ST_NO_SCOPE;
                            end else begin
                                // count read of the top scope is in flight
                                n_top   = top_now;
                                n_base  = ADDR_W'(top_now) * ADDR_W'(MAX_CASES);
                                n_state = S_CNT;
                            end
                        end
                        REQ_CLOSE: begin
                            if (r_open == '0) begin
                                n_status = ST_NO_SCOPE;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_waddr = top_now;
                                n_open    = r_open - DEPTH_W'(1);
                                n_status  = ST_OK;
                            end
                        end
                        REQ_NONE: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_CNT: begin
                n_cnt   = cnt_rdata;
                n_idx   = '0;
                n_pend  = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                priority if (hit) begin
                    n_status = ST_DUP;
                    n_pend   = 1'b0;
                    n_state  = S_FIN;
                end else if (!issue) begin
                    if (r_cnt >= CNT_W'(MAX_CASES)) begin
                        n_status = ST_LIST_FULL;
                    end else begin
                        st_we     = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_waddr = r_top;
                        cnt_wdata = r_cnt + CNT_W'(1);
                        n_status  = ST_OK;
                    end
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_idx  = r_idx + CNT_W'(1);
                    n_pend = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_status;
                    n_out.depth  = DEPTH_OW'(r_open);
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_base   <= n_base;
        r_val    <= n_val;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`include "nested_case_duplicate_checker_macros.svh"

    `NCDC_ASSERT_SAME(a_open_bound, 1'b1, r_open <= DEPTH_W'(MAX_NEST))
    `NCDC_ASSERT_SAME(a_scan_bound, r_state == S_SCAN,
        (r_idx <= r_cnt) && (r_cnt <= CNT_W'(MAX_CASES)))
    `NCDC_ASSERT_NEXT(a_accept_busy, i_req_valid && !o_req_stall, r_state != S_IDLE)

endmodule
